// ===== sv/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants and types for the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int unsigned COLUMNS   = 80;
  localparam int unsigned CELLS     = 2000;
  localparam int unsigned CELLS_MOD = CELLS % COLUMNS;

  localparam int unsigned POS_W = $clog2(CELLS + 1);
  localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [7:0]  CODE_LF = 8'd10;
  localparam logic [7:0]  CODE_CR = 8'd13;

  localparam logic [3:0]  REG_CURSOR_LO = 4'hF;
  localparam logic [3:0]  REG_CURSOR_HI = 4'hE;
  localparam logic [3:0]  REG_NONE      = 4'h0;

  localparam logic        KIND_CELL   = 1'b0;
  localparam logic        KIND_CURSOR = 1'b1;

  localparam logic [31:0] BASE_RESET = 32'h000B_8000;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] color;
    logic       raw;
    logic       end_of_string;
  } item_t;

  // Work left over from one input item for the output sequencer.
  typedef struct packed {
    logic             cell_en;
    logic             cur_en;
    logic [31:0]      addr;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic [POS_W-1:0] pos;
  } cmd_t;

endpackage

// ===== sv/tmcw_step.sv =====
// ----------------------------------------------------------------------------
// tmcw_step
// Cursor state and per-character decode: position/column update and the
// cell write address.
// ----------------------------------------------------------------------------
module tmcw_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  tmcw_pkg::item_t item_i,
  input  logic [31:0]     base_i,
  output tmcw_pkg::cmd_t  cmd_o
);
  import tmcw_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pre_pos;
  logic [COL_W-1:0] col_q, col_d, pre_col;
  logic [POS_W:0]   lf_sum;
  logic             is_lf, is_cr, lf_sat, cell_en;

  always_comb begin
    is_lf   = !item_i.raw && (item_i.char_code == CODE_LF);
    is_cr   = !item_i.raw && (item_i.char_code == CODE_CR);
    lf_sum  = {1'b0, pos_q} + (POS_W+1)'(COLUMNS);
    lf_sat  = lf_sum > (POS_W+1)'(CELLS);
    pre_pos = pos_q;
    pre_col = col_q;
    if (is_lf) begin
      pre_pos = lf_sat ? POS_W'(CELLS) : lf_sum[POS_W-1:0];
      pre_col = lf_sat ? COL_W'(CELLS_MOD) : col_q;
    end else if (is_cr) begin
      pre_pos = pos_q - POS_W'(col_q);
      pre_col = '0;
    end
    cell_en = !is_lf && !is_cr && (pre_pos < POS_W'(CELLS));
    pos_d   = pre_pos;
    col_d   = pre_col;
    if (cell_en) begin
      pos_d = pre_pos + POS_W'(1);
      col_d = (pre_col == COL_W'(COLUMNS - 1)) ? '0 : pre_col + COL_W'(1);
    end
    cmd_o.cell_en = cell_en;
    cmd_o.cur_en  = item_i.raw || item_i.end_of_string;
    cmd_o.addr    = base_i + 32'({pre_pos, 1'b0});
    cmd_o.ch      = item_i.char_code;
    cmd_o.attr    = item_i.color;
    cmd_o.pos     = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      col_q <= '0;
    end else if (adv_i) begin
      pos_q <= pos_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== sv/tmcw_emit.sv =====
// ----------------------------------------------------------------------------
// tmcw_emit
// Result register and sequencer: sends the cell write and the two cursor
// register writes that one character needs as separate transfers.
// ----------------------------------------------------------------------------
module tmcw_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  tmcw_pkg::cmd_t cmd_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           kind_o,
  output logic [31:0]    mem_address_o,
  output logic [7:0]     char_out_o,
  output logic [7:0]     attr_out_o,
  output logic [3:0]     cursor_reg_o,
  output logic [7:0]     cursor_byte_o,
  output logic           last_o
);
  import tmcw_pkg::*;

  typedef enum logic [1:0] {
    PH_CELL,
    PH_LO,
    PH_HI
  } phase_e;

  phase_e      phase_q;
  logic        vld_q;
  cmd_t        cmd_q;
  logic        is_last;
  logic [15:0] pos16;

  assign pos16   = 16'(cmd_q.pos);
  assign is_last = (phase_q == PH_HI) || ((phase_q == PH_CELL) && !cmd_q.cur_en);
  assign free_o  = !vld_q || (out_ready_i && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= PH_CELL;
    end else if (load_i) begin
      vld_q   <= cmd_i.cell_en || cmd_i.cur_en;
      phase_q <= cmd_i.cell_en ? PH_CELL : PH_LO;
    end else if (vld_q && out_ready_i) begin
      if (is_last) begin
        vld_q <= 1'b0;
      end else begin
        unique case (phase_q)
          PH_CELL: phase_q <= PH_LO;
          PH_LO:   phase_q <= PH_HI;
          default: phase_q <= PH_HI;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q <= cmd_i;
    end
  end

  always_comb begin
    out_valid_o   = vld_q;
    last_o        = is_last;
    kind_o        = KIND_CURSOR;
    mem_address_o = '0;
    char_out_o    = '0;
    attr_out_o    = '0;
    cursor_reg_o  = REG_NONE;
    cursor_byte_o = '0;
    unique case (phase_q)
      PH_CELL: begin
        kind_o        = KIND_CELL;
        mem_address_o = cmd_q.addr;
        char_out_o    = cmd_q.ch;
        attr_out_o    = cmd_q.attr;
      end
      PH_LO: begin
        cursor_reg_o  = REG_CURSOR_LO;
        cursor_byte_o = pos16[7:0];
      end
      PH_HI: begin
        cursor_reg_o  = REG_CURSOR_HI;
        cursor_byte_o = pos16[15:8];
      end
      default: begin
        cursor_reg_o  = REG_NONE;
      end
    endcase
  end

endmodule

// ===== sv/text_mode_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Teletype-style writer for a text-mode character buffer.
//
// Input channel (in_valid_i/in_ready_o): one character per transfer with its
// attribute, raw flag and end-of-string mark. Output channel
// (out_valid_o/out_ready_i): one buffer cell write or cursor register write
// per transfer; last_o marks the final result of a character.
// Characters land in an input register, are decoded against the cursor
// state and handed to the result register, which sends the first result.
// Back-to-back characters with one cell write flow at one per cycle while
// out_ready_i stays high; a character that also updates the cursor holds the
// output until the sequencer has sent its cursor low and high byte writes.
// Non-raw line feed or carriage return with no end mark gives no output.
// When the receiver stalls, the current result holds and the input register
// fills, then in_ready_o drops. Reset puts the cursor at cell 0 and the
// buffer base at 0xB8000; cfg_we_i writes the base, and the user must assert
// it only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  color_i,
  input  logic        raw_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [31:0] mem_address_o,
  output logic [7:0]  char_out_o,
  output logic [7:0]  attr_out_o,
  output logic [3:0]  cursor_reg_o,
  output logic [7:0]  cursor_byte_o,
  output logic        last_o
);
  import tmcw_pkg::*;

  logic        in_vld_q;
  item_t       item_q;
  logic [31:0] base_q;
  logic        free, adv;
  cmd_t        cmd;

  assign adv        = in_vld_q && free;
  assign in_ready_o = !in_vld_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      base_q   <= BASE_RESET;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{char_code: char_code_i, color: color_i, raw: raw_i,
                  end_of_string: end_of_string_i};
    end
  end

  tmcw_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .base_i (base_q),
    .cmd_o  (cmd)
  );

  tmcw_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (adv),
    .cmd_i         (cmd),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .mem_address_o (mem_address_o),
    .char_out_o    (char_out_o),
    .attr_out_o    (attr_out_o),
    .cursor_reg_o  (cursor_reg_o),
    .cursor_byte_o (cursor_byte_o),
    .last_o        (last_o)
  );

  a_hi_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cursor_reg_o == REG_CURSOR_HI) |-> last_o)
    else $error("cursor high byte not marked last");

  a_lo_then_hi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && cursor_reg_o == REG_CURSOR_LO) |=>
    (out_valid_o && cursor_reg_o == REG_CURSOR_HI))
    else $error("cursor low byte not followed by high byte");

  a_cell_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_CELL) |->
    (cursor_reg_o == REG_NONE && cursor_byte_o == 8'd0))
    else $error("cell write carries cursor fields");

  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_valid_o))
    else $error("input stalled without pending work");

endmodule
